// File: rtl/core/dtvf_pkg.sv
// Shared types and constants for the depth temporal variance filter.
`timescale 1ns / 1ps

package dtvf_pkg;

	// Field widths of the stream items and registers
	localparam int FIELD_W     = 16;
	localparam int DEPTH_W     = 12;
	localparam int LIMIT_W     = 30;
	localparam int OFFSET_W    = 16;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 32;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 30;

	localparam logic [CFG_IDX_W-1:0] REG_DEV_LIMIT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_OFFSET = 1'b1;

	localparam logic [LIMIT_W-1:0]  DEV_LIMIT_RST   = 30'd1000;
	localparam logic [OFFSET_W-1:0] CLIP_OFFSET_RST = 16'd300;

	// Raw samples above this value are invalid and read as zero
	localparam logic [FIELD_W-1:0] INVALID_ABOVE = 16'd4090;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clear;   // write a zero word at the clear address
		logic load;    // capture the input item
		logic read;    // read the pixel's history word
		logic update;  // replace the current slot, write back, set up accumulation
		logic accum;   // square and accumulate one history lane
		logic finish;  // load the output register
	} dtvf_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clear_last;  // last address of the clearing pass
		logic accum_last;  // last accumulation step; the final lane is summed at its end
		logic out_free;    // output register can take a result
	} dtvf_status_t;

endpackage

// File: rtl/core/dtvf_ctrl.sv
// Controller state machine for the depth temporal variance filter.
`timescale 1ns / 1ps

module dtvf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_tvalid,
	output logic                  in_tready,
	output dtvf_pkg::dtvf_cmd_t   cmd,
	input  dtvf_pkg::dtvf_status_t status
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_UPDATE,
		S_ACCUM,
		S_FINISH
	} ctrl_state_t;

	ctrl_state_t state_q;
	logic        ready_q;

	// Sequence one item at a time; ready is high only while waiting for an item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ready_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (status.clear_last) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_IDLE: begin
					if (in_tvalid) begin
						state_q <= S_READ;
						ready_q <= 1'b0;
					end
				end
				S_READ: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					state_q <= S_ACCUM;
				end
				S_ACCUM: begin
					if (status.accum_last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (status.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_CLEAR;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_tready = ready_q;

	// Decode commands from the state
	always_comb begin
		cmd        = '0;
		cmd.clear  = (state_q == S_CLEAR);
		cmd.load   = ready_q && in_tvalid;
		cmd.read   = (state_q == S_READ);
		cmd.update = (state_q == S_UPDATE);
		cmd.accum  = (state_q == S_ACCUM);
		cmd.finish = (state_q == S_FINISH) && status.out_free;
	end

`ifndef SYNTHESIS
	// Ready tracks the idle state exactly
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q == (state_q == S_IDLE))
		else $error("ready out of step with idle state");
`endif

endmodule

// File: rtl/core/dtvf_datapath.sv
// Datapath of the depth temporal variance filter: history memory, squarer, output register.
`timescale 1ns / 1ps

module dtvf_datapath #(
	parameter int HISTORY_DEPTH = 8,
	parameter int PIXEL_COUNT   = 65536
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dtvf_pkg::dtvf_cmd_t                   cmd,
	output dtvf_pkg::dtvf_status_t                status,
	input  logic [dtvf_pkg::IN_TDATA_W-1:0]       in_tdata,
	input  logic                                  in_tlast,
	output logic                                  out_tvalid,
	input  logic                                  out_tready,
	output logic [dtvf_pkg::OUT_TDATA_W-1:0]      out_tdata,
	output logic                                  out_tuser,
	input  logic                                  cfg_we,
	input  logic [dtvf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dtvf_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int FIELD_W  = dtvf_pkg::FIELD_W;
	localparam int DEPTH_W  = dtvf_pkg::DEPTH_W;
	localparam int LIMIT_W  = dtvf_pkg::LIMIT_W;
	localparam int OFFSET_W = dtvf_pkg::OFFSET_W;

	localparam int ADDR_W  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
	localparam int LANE_W  = $clog2(HISTORY_DEPTH);
	localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W   = DEPTH_W + LANE_W;
	localparam int HIST_W  = HISTORY_DEPTH * DEPTH_W;
	localparam int WORD_W  = HIST_W + SUM_W;
	localparam int SQ_W    = 2 * SUM_W;
	localparam int ACC_W   = SQ_W + LANE_W;
	localparam int NN      = HISTORY_DEPTH * HISTORY_DEPTH;
	localparam int NN_W    = $clog2(NN + 1);
	localparam int LIM_W   = LIMIT_W + NN_W;
	localparam int CMP_W   = (ACC_W > LIM_W) ? ACC_W : LIM_W;
	localparam int SUM_MAX = HISTORY_DEPTH * 4090;

	// Configuration registers
	logic [LIMIT_W-1:0]  dev_limit_q;
	logic [OFFSET_W-1:0] clip_offset_q;

	// Captured item
	logic [FIELD_W-1:0] idx_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [FIELD_W-1:0] hand_q;
	logic               last_q;
	logic               in_range_q;

	// Control state
	logic [LANE_W-1:0] slot_q;
	logic [ADDR_W-1:0] clr_q;
	logic [CNT_W-1:0]  cnt_q;

	// History memory: all lanes of one pixel plus their sum in one word
	logic [WORD_W-1:0] mem [PIXEL_COUNT];
	logic [WORD_W-1:0] rd_q;
	logic [WORD_W-1:0] word_q;

	// Accumulation
	logic [SQ_W-1:0]  prod_s1;
	logic [ACC_W-1:0] acc_q;
	logic [LIM_W-1:0] lim_q;
	logic             win_q;

	// Output register
	logic               out_valid_q;
	logic [FIELD_W-1:0] out_idx_q;
	logic [DEPTH_W-1:0] out_depth_q;
	logic               out_keep_q;

	// Combinational signals
	logic [FIELD_W-1:0] raw_depth;
	logic [FIELD_W-1:0] raw_idx;
	logic               raw_in_range;
	logic [DEPTH_W-1:0] old_depth;
	logic [SUM_W-1:0]   rd_sum;
	logic [SUM_W-1:0]   new_sum;
	logic [WORD_W-1:0]  new_word;
	logic               win;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_wa;
	logic [WORD_W-1:0]  mem_wd;
	logic [LANE_W-1:0]  lane_sel;
	logic [DEPTH_W-1:0] lane_depth;
	logic [SUM_W-1:0]   word_sum;
	logic [SUM_W-1:0]   lane_scaled;
	logic [SUM_W-1:0]   abs_dev;
	logic [SQ_W-1:0]    sq;

	assign raw_depth    = in_tdata[FIELD_W-1:0];
	assign raw_idx      = in_tdata[2*FIELD_W-1:FIELD_W];
	assign raw_in_range = ({1'b0, raw_idx} < (FIELD_W + 1)'(PIXEL_COUNT));

	// Take register writes at any time; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_limit_q   <= dtvf_pkg::DEV_LIMIT_RST;
			clip_offset_q <= dtvf_pkg::CLIP_OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dtvf_pkg::REG_DEV_LIMIT:   dev_limit_q   <= cfg_data[LIMIT_W-1:0];
				dtvf_pkg::REG_CLIP_OFFSET: clip_offset_q <= cfg_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// Replace the current slot of the read word and fix up the sum
	always_comb begin
		old_depth = rd_q[slot_q*DEPTH_W +: DEPTH_W];
		rd_sum    = rd_q[WORD_W-1 -: SUM_W];
		new_sum   = rd_sum - SUM_W'(old_depth) + SUM_W'(depth_q);
		new_word  = rd_q;
		for (int b = 0; b < HISTORY_DEPTH; b++) begin
			if (LANE_W'(b) == slot_q) begin
				new_word[b*DEPTH_W +: DEPTH_W] = depth_q;
			end
		end
		new_word[WORD_W-1 -: SUM_W] = new_sum;
	end

	// Depth window: hand - offset < depth < hand + offset, kept non-negative
	assign win = (({1'b0, 4'b0, depth_q} + {1'b0, clip_offset_q}) > {1'b0, hand_q}) &&
		({1'b0, 4'b0, depth_q} < ({1'b0, hand_q} + {1'b0, clip_offset_q}));

	// Single write port, shared by the clearing pass and the update
	assign mem_we = cmd.clear || (cmd.update && in_range_q);
	assign mem_wa = cmd.clear ? clr_q : idx_q[ADDR_W-1:0];
	assign mem_wd = cmd.clear ? '0 : new_word;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.read) begin
			rd_q <= mem[idx_q[ADDR_W-1:0]];
		end
	end

	// Deviation of one lane: |N*x - S|, then its square
	assign lane_sel    = cnt_q[LANE_W-1:0];
	assign lane_depth  = word_q[lane_sel*DEPTH_W +: DEPTH_W];
	assign word_sum    = word_q[WORD_W-1 -: SUM_W];
	assign lane_scaled = SUM_W'(lane_depth) * SUM_W'(HISTORY_DEPTH);
	assign abs_dev     = (lane_scaled >= word_sum) ? (lane_scaled - word_sum)
		: (word_sum - lane_scaled);
	assign sq          = SQ_W'(abs_dev) * SQ_W'(abs_dev);

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q      <= raw_idx;
			depth_q    <= (raw_depth > dtvf_pkg::INVALID_ABOVE) ? '0
				: raw_depth[DEPTH_W-1:0];
			hand_q     <= in_tdata[3*FIELD_W-1:2*FIELD_W];
			last_q     <= in_tlast;
			in_range_q <= raw_in_range;
		end
		if (cmd.update) begin
			word_q  <= new_word;
			win_q   <= win;
			lim_q   <= LIM_W'(dev_limit_q) * LIM_W'(NN);
			prod_s1 <= '0;
			acc_q   <= '0;
		end else if (cmd.accum) begin
			prod_s1 <= ({1'b0, cnt_q} < (CNT_W + 1)'(HISTORY_DEPTH)) ? sq : '0;
			acc_q   <= acc_q + ACC_W'(prod_s1);
		end
		if (cmd.finish) begin
			out_idx_q   <= idx_q;
			out_depth_q <= depth_q;
			out_keep_q  <= in_range_q && win_q &&
				(CMP_W'(acc_q) < CMP_W'(lim_q));
		end
	end

	// Control registers: clear address, lane count, slot, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cnt_q       <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.update) begin
				cnt_q <= '0;
			end else if (cmd.accum) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.finish && last_q) begin
				slot_q <= (slot_q == LANE_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		status            = '0;
		status.clear_last = (clr_q == ADDR_W'(PIXEL_COUNT - 1));
		status.accum_last = (cnt_q == CNT_W'(HISTORY_DEPTH));
		status.out_free   = !out_valid_q || out_tready;
	end

	assign out_tvalid = out_valid_q;
	assign out_tdata  = {4'b0, out_depth_q, out_idx_q};
	assign out_tuser  = out_keep_q;

`ifndef SYNTHESIS
	// Slot stays inside the ring
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, slot_q} < (LANE_W + 1)'(HISTORY_DEPTH))
		else $error("history slot out of range");

	// Lane count never runs past the last lane plus the drain cycle
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accum |-> ({1'b0, cnt_q} <= (CNT_W + 1)'(HISTORY_DEPTH)))
		else $error("lane count overran");

	// Running sum cannot exceed the full history at the largest depth
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && in_range_q) |-> ({1'b0, new_sum} <= (SUM_W + 1)'(SUM_MAX)))
		else $error("history sum out of bounds");
`endif

endmodule

// File: rtl/core/depth_temporal_variance_filter_top.sv
// Top level of the depth temporal variance filter.
//
//   group    dir  handshake                  payload
//   s_axis   in   s_axis_tvalid/tready       tdata {hand_depth_mm, pixel_index, depth_raw},
//                                            tlast last_in_frame
//   m_axis   out  m_axis_tvalid/tready       tdata {pad, depth_mm, out_index}, tuser keep
//   cfg      in   cfg_we                     cfg_index, cfg_data
//
// Each item passes in turn through accept, history read, slot update and write-back,
// the shared squarer visiting each history lane in turn plus a drain step, and result
// load, which waits for the output register to be free; items are taken one at a time.
// After reset a clearing pass writes zero to every history word, with s_axis_tready
// low; register writes are taken throughout.
// A stalled result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps

module depth_temporal_variance_filter_top #(
	parameter int HISTORY_DEPTH = 8,
	parameter int PIXEL_COUNT   = 65536
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// depth_raw [15:0], pixel_index [31:16], hand_depth_mm [47:32]
	input  logic [dtvf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// out_index [15:0], depth_mm [27:16], zero [31:28]
	output logic [dtvf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// keep [0]
	output logic                                m_axis_tuser,
	input  logic                                cfg_we,
	input  logic [dtvf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dtvf_pkg::CFG_DATA_W-1:0]     cfg_data
);

	dtvf_pkg::dtvf_cmd_t    cmd;
	dtvf_pkg::dtvf_status_t status;

	// Sequence items
	dtvf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_axis_tvalid),
		.in_tready (s_axis_tready),
		.cmd       (cmd),
		.status    (status)
	);

	// Hold history and compute results
	dtvf_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.PIXEL_COUNT   (PIXEL_COUNT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_tdata   (s_axis_tdata),
		.in_tlast   (s_axis_tlast),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (m_axis_tuser),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

endmodule
